>>> rtl/core/ptld_pkg.sv
// Shared constants for the proximity-toggle LED dimmer.
`default_nettype none

package ptld_pkg;

    // Field widths
    localparam int unsigned LEVEL_W = 19;
    localparam int unsigned DIST_W  = 20;
    localparam int unsigned DUTY_W  = 14;
    localparam int unsigned PCT_W   = 7;

    // Item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_DIST   = 2'd2;

    // Command ids
    localparam logic [7:0] CMD_MANUAL    = 8'h01;
    localparam logic [7:0] CMD_AUTOMATIC = 8'h02;
    localparam logic [7:0] CMD_ON        = 8'h03;
    localparam logic [7:0] CMD_OFF       = 8'h04;
    localparam logic [7:0] CMD_INTENSITY = 8'h05;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_NEAR = 1'b0,
        CFG_FAR  = 1'b1
    } t_cfg_reg;

    // Levels and scaling
    localparam logic [LEVEL_W-1:0] FULL_LEVEL       = 19'd350000;
    localparam logic [11:0]        STEP_PER_PERCENT = 12'd3500;
    localparam logic [PCT_W-1:0]   MAX_PERCENT      = 7'd100;

    // Threshold reset values
    localparam logic [DIST_W-1:0] NEAR_RESET = 20'd100000;
    localparam logic [DIST_W-1:0] FAR_RESET  = 20'd130000;

    // Divide by 35 as multiply by ceil(2^25 / 35), exact for any 19-bit level
    localparam int unsigned        RECIP_SHIFT = 25;
    localparam logic [19:0]        RECIP_35    = 20'd958699;

endpackage

`default_nettype wire

>>> rtl/core/proximity_toggle_led_dimmer.sv
// Top level of the proximity-toggle LED dimmer: state update and result register.
`default_nettype none

// A brightness level ramps one step per tick toward a target; every transfer
// in yields exactly one result carrying the duty (level before the item divided
// by 35), the level and target after the item, and the mode flag. Items are
// taken one per clock while the input is not stalled: state is updated in the
// cycle of the transfer and the result appears in the output register on the
// next cycle. New items are refused only while a result waits under output stall.
// Thresholds are written through the configuration channel, which is always
// ready; the divide by 35 is one reciprocal multiply ahead of the output reg.
module proximity_toggle_led_dimmer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_packet_type,
    input  wire logic [7:0]  i_packet_data,
    input  wire logic [19:0] i_distance,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [13:0]      o_duty,
    output logic [18:0]      o_level,
    output logic [18:0]      o_target,
    output logic             o_auto_mode,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    localparam int unsigned LW = ptld_pkg::LEVEL_W;
    localparam int unsigned DW = ptld_pkg::DIST_W;
    localparam int unsigned PW = LW + 20;

    // State
    logic [LW-1:0] r_level, n_level;
    logic [LW-1:0] r_target, n_target;
    logic          r_auto, n_auto;
    logic          r_latch, n_latch;
    logic [DW-1:0] r_near, r_far;

    // Result register
    logic                       r_out_valid;
    logic [ptld_pkg::DUTY_W-1:0] r_duty;
    logic [LW-1:0]              r_out_level, r_out_target;
    logic                       r_out_auto;

    logic                       in_xfer;
    logic                       out_xfer;
    logic [PW-1:0]              duty_prod;
    logic [ptld_pkg::PCT_W-1:0] pct;
    logic [LW-1:0]              pct_level;

    // Handshakes
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Duty from the level before the item
    assign duty_prod = PW'(r_level) * PW'(ptld_pkg::RECIP_35);

    // Intensity percent, saturated, scaled to a level
    always_comb begin
        if (i_packet_data > 8'(ptld_pkg::MAX_PERCENT)) begin
            pct = ptld_pkg::MAX_PERCENT;
        end else begin
            pct = i_packet_data[ptld_pkg::PCT_W-1:0];
        end
        pct_level = LW'(pct) * LW'(ptld_pkg::STEP_PER_PERCENT);
    end

    // Next state for one item
    always_comb begin
        n_level  = r_level;
        n_target = r_target;
        n_auto   = r_auto;
        n_latch  = r_latch;
        unique case (i_mode)
            ptld_pkg::KIND_TICK: begin
                if (r_level > r_target) begin
                    n_level = r_level - LW'(1);
                end else if (r_level < r_target) begin
                    n_level = r_level + LW'(1);
                end
            end
            ptld_pkg::KIND_PACKET: begin
                unique case (i_packet_type)
                    ptld_pkg::CMD_MANUAL:    n_auto = 1'b0;
                    ptld_pkg::CMD_AUTOMATIC: n_auto = 1'b1;
                    ptld_pkg::CMD_ON: begin
                        if (!r_auto) n_target = ptld_pkg::FULL_LEVEL;
                    end
                    ptld_pkg::CMD_OFF: begin
                        if (!r_auto) n_target = '0;
                    end
                    ptld_pkg::CMD_INTENSITY: begin
                        if (!r_auto) n_target = pct_level;
                    end
                    default: ;
                endcase
            end
            ptld_pkg::KIND_DIST: begin
                // toggle check first, release check second
                if (i_distance < r_near && !r_latch) begin
                    if (r_auto) begin
                        n_target = (r_target != '0) ? '0 : ptld_pkg::FULL_LEVEL;
                    end
                    n_latch = 1'b1;
                end
                if (i_distance > r_far) begin
                    n_latch = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_target <= '0;
            r_auto   <= 1'b0;
            r_latch  <= 1'b0;
        end else if (in_xfer) begin
            r_level  <= n_level;
            r_target <= n_target;
            r_auto   <= n_auto;
            r_latch  <= n_latch;
        end
    end

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= ptld_pkg::NEAR_RESET;
            r_far  <= ptld_pkg::FAR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ptld_pkg::t_cfg_reg'(i_cfg_index))
                ptld_pkg::CFG_NEAR: r_near <= i_cfg_data;
                ptld_pkg::CFG_FAR:  r_far  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_duty       <= duty_prod[ptld_pkg::RECIP_SHIFT +: ptld_pkg::DUTY_W];
            r_out_level  <= n_level;
            r_out_target <= n_target;
            r_out_auto   <= n_auto;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_level     = r_out_level;
    assign o_target    = r_out_target;
    assign o_auto_mode = r_out_auto;

    // Checks
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ptld_pkg::FULL_LEVEL)
        else $error("level above full scale");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target <= ptld_pkg::FULL_LEVEL)
        else $error("target above full scale");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == $past(r_level)) || (r_level == $past(r_level) + LW'(1))
        || (r_level == $past(r_level) - LW'(1)))
        else $error("level moved by more than one step");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted item produced no result");

    a_level_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_mode != ptld_pkg::KIND_TICK) |=> $stable(r_level))
        else $error("level moved on a non-tick item");

endmodule

`default_nettype wire
